// File: hdl/smpc_pkg.sv
// Package: shared constants, register codes and the rain code table of the pump controller.
`default_nettype none

package smpc_pkg;

    // Default design parameters.
    localparam int ADC_BITS    = 12;
    localparam int DRY_READING = 3500;

    // Field widths.
    localparam int WEATHER_W  = 11;
    localparam int PCT_W      = 8;
    localparam int THR_W      = 7;
    localparam int INTERVAL_W = 31;
    localparam int SHORT_W    = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_INTERVAL  = 3'd2,
        CFG_PUMP_TIME = 3'd3,
        CFG_SETTLE    = 3'd4
    } t_cfg_idx;

    // Register reset values.
    localparam logic              RST_ENABLE    = 1'b0;
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 7'd60;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 31'd10000;
    localparam logic [SHORT_W-1:0] RST_PUMP_TIME = 16'd5000;
    localparam logic [SHORT_W-1:0] RST_SETTLE    = 16'd5000;

    // Intervals at or below this value keep the controller frozen.
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL = 31'd1000;

    // Scale factor of the percentage map.
    localparam int PCT_SCALE = 99;

    // Weather codes that count as rain.
    localparam int RAIN_N = 15;
    localparam logic [WEATHER_W-1:0] RAIN_CODES [RAIN_N] = '{
        11'd1063, 11'd1180, 11'd1183, 11'd1186, 11'd1189, 11'd1192, 11'd1195, 11'd1198,
        11'd1201, 11'd1204, 11'd1240, 11'd1243, 11'd1246, 11'd1273, 11'd1276
    };

    function automatic logic is_rain(input logic [WEATHER_W-1:0] code);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < RAIN_N; k++) begin
            if (code == RAIN_CODES[k]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: hdl/smpc_ifs.sv
// Interfaces: valid/ready channels for soil ticks in and pump status words out.
`default_nettype none

interface smpc_in_if #(
    parameter int ADC_BITS = smpc_pkg::ADC_BITS
);
    logic                             valid;
    logic                             ready;
    logic [ADC_BITS-1:0]              soil_sample;
    logic [smpc_pkg::WEATHER_W-1:0]   weather_code;

    modport source (output valid, output soil_sample, output weather_code, input ready);
    modport sink   (input valid, input soil_sample, input weather_code, output ready);
endinterface

interface smpc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               pump_on;
    logic                               watering_active;
    logic signed [smpc_pkg::PCT_W-1:0]  moisture_percent;

    modport source (output valid, output pump_on, output watering_active,
                    output moisture_percent, input ready);
    modport sink   (input valid, input pump_on, input watering_active,
                    input moisture_percent, output ready);
endinterface

`default_nettype wire

// File: hdl/soil_moisture_pump_controller_core.sv
// Top level: soil moisture pump controller, percentage map pipeline and watering timers.
// A word accepted at the input passes the input, product and quotient stages to the output.
// Throughput: one word per cycle, unless the output stalls, through four register stages (input, product, quotient,
// result); the timer state steps once per word as it moves into the result stage.
// A stalled output backs up stage by stage; input stalls only when all four stages are full.
// Reset: synchronous, active low; clears valids, timers, watering flag and pump level.
`default_nettype none

module soil_moisture_pump_controller_core #(
    parameter int ADC_BITS    = smpc_pkg::ADC_BITS,
    parameter int DRY_READING = smpc_pkg::DRY_READING
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    smpc_in_if.sink                                i_in,
    smpc_out_if.source                             o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [smpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [smpc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    // ------------------------------------------------------------------
    // Divider constants. The map is q = |D - x| * 99 / D, done as a
    // multiply by a rounded-up reciprocal; the shift K is wide enough that
    // the quotient is exact for every product below 2^PROD_W.
    // ------------------------------------------------------------------
    localparam int D_BITS   = $clog2(DRY_READING + 1);
    localparam int DIFF_W   = (ADC_BITS > D_BITS) ? ADC_BITS : D_BITS;
    localparam int PROD_W   = DIFF_W + 7;
    localparam int D_W      = $clog2(DRY_READING);
    localparam int K        = PROD_W + D_W;
    localparam int RECIP_W  = PROD_W + 2;
    localparam int MUL_W    = PROD_W + RECIP_W;
    localparam int Q_W      = PROD_W - D_W + 1;
    localparam int P_W      = Q_W + 2;
    localparam int CMP_W    = (P_W > smpc_pkg::PCT_W) ? P_W : smpc_pkg::PCT_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << K) + 64'(DRY_READING) - 64'd1) / 64'(DRY_READING));

    localparam int IW = smpc_pkg::INTERVAL_W;
    localparam int SW = smpc_pkg::SHORT_W;
    localparam int WW = smpc_pkg::WEATHER_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                           r_enable;
    logic [smpc_pkg::THR_W-1:0]     r_thr;
    logic [IW-1:0]                  r_interval;
    logic [SW-1:0]                  r_pump_time;
    logic [SW-1:0]                  r_settle_time;
    logic                           w_cfg_hit;

    // A write to any listed register also stops the timers.
    always_comb begin
        case (smpc_pkg::t_cfg_idx'(i_cfg_idx))
            smpc_pkg::CFG_ENABLE,
            smpc_pkg::CFG_THRESHOLD,
            smpc_pkg::CFG_INTERVAL,
            smpc_pkg::CFG_PUMP_TIME,
            smpc_pkg::CFG_SETTLE:    w_cfg_hit = i_cfg_we;
            default:                 w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= smpc_pkg::RST_ENABLE;
            r_thr         <= smpc_pkg::RST_THRESHOLD;
            r_interval    <= smpc_pkg::RST_INTERVAL;
            r_pump_time   <= smpc_pkg::RST_PUMP_TIME;
            r_settle_time <= smpc_pkg::RST_SETTLE;
        end else if (i_cfg_we) begin
            case (smpc_pkg::t_cfg_idx'(i_cfg_idx))
                smpc_pkg::CFG_ENABLE:    r_enable      <= i_cfg_wdata[0];
                smpc_pkg::CFG_THRESHOLD: r_thr         <= i_cfg_wdata[smpc_pkg::THR_W-1:0];
                smpc_pkg::CFG_INTERVAL:  r_interval    <= i_cfg_wdata[IW-1:0];
                smpc_pkg::CFG_PUMP_TIME: r_pump_time   <= i_cfg_wdata[SW-1:0];
                smpc_pkg::CFG_SETTLE:    r_settle_time <= i_cfg_wdata[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or the stage
    // after it moves on. The result stage moves when the output is free.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_ov;
    logic w_take_out, w_en3, w_en2, w_en1, w_s3_go;

    assign w_take_out = !r_ov || o_out.ready;
    assign w_en3      = !r_v3 || w_take_out;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign w_s3_go    = r_v3 && w_take_out;
    assign i_in.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1)      r_v1 <= i_in.valid;
            if (w_en2)      r_v2 <= r_v1;
            if (w_en3)      r_v3 <= r_v2;
            if (w_take_out) r_ov <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0] r_s1_sample;
    logic [WW-1:0]       r_s1_weather;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_sample  <= i_in.soil_sample;
            r_s1_weather <= i_in.weather_code;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude of the distance from the dry reading, times 99.
    // Readings above the dry point give one minus the quotient, negative once the quotient exceeds one.
    // ------------------------------------------------------------------
    logic [DIFF_W:0]   w_x, w_d;
    logic              w_neg;
    logic [DIFF_W-1:0] w_mag;
    logic [PROD_W-1:0] r_s2_prod;
    logic              r_s2_neg;
    logic [WW-1:0]     r_s2_weather;

    always_comb begin
        w_x   = (DIFF_W+1)'(r_s1_sample);
        w_d   = (DIFF_W+1)'(DRY_READING);
        w_neg = (w_x > w_d);
        w_mag = w_neg ? DIFF_W'(w_x - w_d) : DIFF_W'(w_d - w_x);
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_prod    <= PROD_W'(w_mag) * PROD_W'(smpc_pkg::PCT_SCALE);
            r_s2_neg     <= w_neg;
            r_s2_weather <= r_s1_weather;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by the dry reading through the reciprocal.
    // Truncating the magnitude truncates toward zero.
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] w_full;
    logic [Q_W-1:0]   r_s3_q;
    logic             r_s3_neg;
    logic [WW-1:0]    r_s3_weather;

    assign w_full = MUL_W'(r_s2_prod) * MUL_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_q       <= w_full[K +: Q_W];
            r_s3_neg     <= r_s2_neg;
            r_s3_weather <= r_s2_weather;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: finish the percentage and step the watering controller.
    // ------------------------------------------------------------------
    logic signed [CMP_W-1:0] w_qs, w_pct, w_thr;
    logic                    w_run, w_rain;

    always_comb begin
        w_qs   = $signed(CMP_W'(r_s3_q));
        w_pct  = r_s3_neg ? ($signed(CMP_W'(1)) - w_qs) : (w_qs + $signed(CMP_W'(1)));
        w_thr  = $signed(CMP_W'(r_thr));
        w_rain = smpc_pkg::is_rain(r_s3_weather);
        w_run  = r_enable && (r_thr != '0) && (r_interval > smpc_pkg::MIN_INTERVAL);
    end

    // Controller state
    logic          r_int_run, n_int_run;
    logic [IW-1:0] r_int_elapsed, n_int_elapsed;
    logic          r_water, n_water;
    logic          r_pump_run, n_pump_run;
    logic [SW-1:0] r_pump_elapsed, n_pump_elapsed;
    logic          r_settle_run, n_settle_run;
    logic [SW-1:0] r_settle_elapsed, n_settle_elapsed;
    logic          r_pump_level, n_pump_level;

    // Steps follow the tick order: advance the running timers, then start
    // or stop interval, pump and settle in turn.
    always_comb begin
        n_int_run        = r_int_run;
        n_int_elapsed    = r_int_elapsed;
        n_water          = r_water;
        n_pump_run       = r_pump_run;
        n_pump_elapsed   = r_pump_elapsed;
        n_settle_run     = r_settle_run;
        n_settle_elapsed = r_settle_elapsed;
        n_pump_level     = r_pump_level;

        if (w_run) begin
            // advance, holding at full scale
            if (r_int_run && (r_int_elapsed != '1)) begin
                n_int_elapsed = r_int_elapsed + IW'(1);
            end
            if (r_pump_run && (r_pump_elapsed != '1)) begin
                n_pump_elapsed = r_pump_elapsed + SW'(1);
            end
            if (r_settle_run && (r_settle_elapsed != '1)) begin
                n_settle_elapsed = r_settle_elapsed + SW'(1);
            end

            // interval timer runs only while not watering
            if (!n_int_run && !n_water) begin
                n_int_run     = 1'b1;
                n_int_elapsed = '0;
            end
            if (n_int_run && (n_int_elapsed >= r_interval)) begin
                n_int_run     = 1'b0;
                n_int_elapsed = '0;
                if ((w_pct <= w_thr) && !w_rain) begin
                    n_water = 1'b1;
                end
            end

            // pump pulse; wet soil cuts it short and goes to settle
            if (n_water && !n_settle_run) begin
                if (w_pct < w_thr) begin
                    if (!n_pump_run) begin
                        n_pump_run     = 1'b1;
                        n_pump_elapsed = '0;
                        n_pump_level   = 1'b1;
                    end else if (n_pump_elapsed >= r_pump_time) begin
                        n_pump_run       = 1'b0;
                        n_pump_elapsed   = '0;
                        n_pump_level     = 1'b0;
                        n_settle_run     = 1'b1;
                        n_settle_elapsed = '0;
                    end
                end else begin
                    n_pump_run       = 1'b0;
                    n_pump_elapsed   = '0;
                    n_pump_level     = 1'b0;
                    n_settle_run     = 1'b1;
                    n_settle_elapsed = '0;
                end
            end

            // settle done: drop watering once the soil reads wet
            if (n_settle_run && (n_settle_elapsed >= r_settle_time)) begin
                n_settle_run     = 1'b0;
                n_settle_elapsed = '0;
                if (w_pct >= w_thr) begin
                    n_water      = 1'b0;
                    n_pump_level = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_run        <= 1'b0;
            r_int_elapsed    <= '0;
            r_water          <= 1'b0;
            r_pump_run       <= 1'b0;
            r_pump_elapsed   <= '0;
            r_settle_run     <= 1'b0;
            r_settle_elapsed <= '0;
            r_pump_level     <= 1'b0;
        end else if (w_cfg_hit) begin
            // stop all timers; flag and pump level hold
            r_int_run        <= 1'b0;
            r_int_elapsed    <= '0;
            r_pump_run       <= 1'b0;
            r_pump_elapsed   <= '0;
            r_settle_run     <= 1'b0;
            r_settle_elapsed <= '0;
        end else if (w_s3_go) begin
            r_int_run        <= n_int_run;
            r_int_elapsed    <= n_int_elapsed;
            r_water          <= n_water;
            r_pump_run       <= n_pump_run;
            r_pump_elapsed   <= n_pump_elapsed;
            r_settle_run     <= n_settle_run;
            r_settle_elapsed <= n_settle_elapsed;
            r_pump_level     <= n_pump_level;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                              r_out_pump, r_out_water;
    logic signed [smpc_pkg::PCT_W-1:0] r_out_pct;

    always_ff @(posedge i_clk) begin
        if (w_s3_go) begin
            r_out_pump  <= n_pump_level;
            r_out_water <= n_water;
            r_out_pct   <= w_pct[smpc_pkg::PCT_W-1:0];
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.pump_on          = r_out_pump;
    assign o_out.watering_active  = r_out_water;
    assign o_out.moisture_percent = r_out_pct;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_level_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pump_level |-> r_water)
        else $error("pump driven without a watering cycle");

    a_pump_settle_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pump_run |-> (!r_settle_run && r_pump_level))
        else $error("pump timer running with settle running or pump off");

    a_interval_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_int_run |-> !r_water)
        else $error("interval timer running during watering");

    a_frozen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s3_go && !w_run && !i_cfg_we) |=>
            ($stable(r_water) && $stable(r_pump_level) && $stable(r_int_elapsed)
             && $stable(r_pump_elapsed) && $stable(r_settle_elapsed)))
        else $error("state changed while controller frozen");

endmodule

`default_nettype wire
